/* src/spfc_pkg.sv */
`default_nettype none

package spfc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COEF_W    = 16;
	localparam int COEF_FRAC = 16;
	localparam int GAIN_FRAC = 14;
	localparam int SMP_W     = 16;
	localparam int MIX_W     = 18;
	localparam int OFF_W     = 17;
	localparam int ST_W      = 40;
	localparam int LI_W      = 18;
	localparam int OUT_FRAC  = 15;

	localparam int SMP_MAX = 2 ** (SMP_W - 1) - 1;
	localparam int SMP_MIN = -(2 ** (SMP_W - 1));

	localparam int OPND_W = ST_W + 1;
	localparam int LO_W   = 24;
	localparam int HI_W   = OPND_W - LO_W;
	localparam int MB_W   = (LO_W + 1 > HI_W) ? LO_W + 1 : HI_W;
	localparam int PROD_W = COEF_W + 1 + MB_W;
	localparam int ACC_W  = OPND_W + COEF_W + 1;
	localparam int R_W    = ST_W - FRAC_BITS;
	localparam int T_W    = R_W + OUT_FRAC + 1;

	localparam int IN_W   = 2 * MIX_W + OFF_W;
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TW = 2 * SMP_W;

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_COEF  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHER_COEF = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_MAKEUP_GAIN   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_COEF = CFG_IDX_W'(3);

	localparam logic [COEF_W-1:0] RST_LOWPASS_COEF  = COEF_W'(2621);
	localparam logic [COEF_W-1:0] RST_SMOOTHER_COEF = COEF_W'(786);
	localparam logic [COEF_W-1:0] RST_MAKEUP_GAIN   = COEF_W'(29491);
	localparam logic [COEF_W-1:0] RST_HIGHPASS_COEF = COEF_W'(64356);

	localparam int PC_W = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LP_DIFF,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_LP_UPD,
		OP_SM_DIFF,
		OP_SM_UPD,
		OP_HP_DIFF,
		OP_HP_UPD,
		OP_OUT,
		OP_DONE
	} op_t;

	typedef enum logic [1:0] {
		CS_LP,
		CS_SM,
		CS_GAIN,
		CS_HP
	} csel_t;

	typedef struct packed {
		op_t   op;
		csel_t csel;
		logic  jmp;
	} ucode_t;

	typedef struct packed {
		op_t   op;
		csel_t csel;
		logic  ch;
	} ctl_t;

	typedef struct packed {
		logic [COEF_W-1:0] lowpass;
		logic [COEF_W-1:0] smoother;
		logic [COEF_W-1:0] gain;
		logic [COEF_W-1:0] highpass;
	} coef_t;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{op: OP_DONE, csel: CS_LP, jmp: 1'b0};
		case (pc)
			PC_W'(0):  w = '{op: OP_LP_DIFF, csel: CS_LP,   jmp: 1'b0};
			PC_W'(1):  w = '{op: OP_MUL_LO,  csel: CS_LP,   jmp: 1'b0};
			PC_W'(2):  w = '{op: OP_MUL_HI,  csel: CS_LP,   jmp: 1'b0};
			PC_W'(3):  w = '{op: OP_LP_UPD,  csel: CS_LP,   jmp: 1'b0};
			PC_W'(4):  w = '{op: OP_SM_DIFF, csel: CS_SM,   jmp: 1'b0};
			PC_W'(5):  w = '{op: OP_MUL_LO,  csel: CS_SM,   jmp: 1'b0};
			PC_W'(6):  w = '{op: OP_MUL_HI,  csel: CS_SM,   jmp: 1'b0};
			PC_W'(7):  w = '{op: OP_SM_UPD,  csel: CS_SM,   jmp: 1'b0};
			PC_W'(8):  w = '{op: OP_MUL_LO,  csel: CS_GAIN, jmp: 1'b0};
			PC_W'(9):  w = '{op: OP_MUL_HI,  csel: CS_GAIN, jmp: 1'b0};
			PC_W'(10): w = '{op: OP_HP_DIFF, csel: CS_HP,   jmp: 1'b0};
			PC_W'(11): w = '{op: OP_MUL_LO,  csel: CS_HP,   jmp: 1'b0};
			PC_W'(12): w = '{op: OP_MUL_HI,  csel: CS_HP,   jmp: 1'b0};
			PC_W'(13): w = '{op: OP_HP_UPD,  csel: CS_HP,   jmp: 1'b0};
			PC_W'(14): w = '{op: OP_OUT,     csel: CS_HP,   jmp: 1'b1};
			default:   w = '{op: OP_DONE,    csel: CS_LP,   jmp: 1'b0};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* src/spfc_dp.sv */
`default_nettype none

module spfc_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire spfc_pkg::ctl_t                       ctl,
	input  wire spfc_pkg::coef_t                      coef,
	input  wire logic signed [spfc_pkg::MIX_W-1:0]    left_mix,
	input  wire logic signed [spfc_pkg::MIX_W-1:0]    right_mix,
	input  wire logic signed [spfc_pkg::OFF_W-1:0]    offset_add,
	output logic signed [spfc_pkg::SMP_W-1:0]         left_res,
	output logic signed [spfc_pkg::SMP_W-1:0]         right_res
);

	localparam int FRAC_BITS = spfc_pkg::FRAC_BITS;
	localparam int COEF_W    = spfc_pkg::COEF_W;
	localparam int COEF_FRAC = spfc_pkg::COEF_FRAC;
	localparam int GAIN_SH   = spfc_pkg::GAIN_FRAC + spfc_pkg::FRAC_BITS;
	localparam int SMP_W     = spfc_pkg::SMP_W;
	localparam int MIX_W     = spfc_pkg::MIX_W;
	localparam int ST_W      = spfc_pkg::ST_W;
	localparam int LI_W      = spfc_pkg::LI_W;
	localparam int DQ_W      = spfc_pkg::LI_W + 1;
	localparam int OUT_FRAC  = spfc_pkg::OUT_FRAC;
	localparam int OPND_W    = spfc_pkg::OPND_W;
	localparam int LO_W      = spfc_pkg::LO_W;
	localparam int MB_W      = spfc_pkg::MB_W;
	localparam int PROD_W    = spfc_pkg::PROD_W;
	localparam int ACC_W     = spfc_pkg::ACC_W;
	localparam int YW_W      = ST_W + 2;
	localparam int R_W       = spfc_pkg::R_W;
	localparam int T_W       = spfc_pkg::T_W;
	localparam int TR_W      = T_W - OUT_FRAC;

	logic signed [ST_W-1:0]   lp_q [2];
	logic signed [ST_W-1:0]   sm_q [2];
	logic signed [ST_W-1:0]   ho_q [2];
	logic signed [LI_W-1:0]   li_q [2];
	logic signed [SMP_W-1:0]  res_q [2];
	logic signed [OPND_W-1:0] opnd_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [LI_W-1:0]   q_q;
	logic signed [R_W-1:0]    r_q;

	logic signed [MIX_W-1:0]  mix_sel;
	logic signed [SMP_W-1:0]  x;
	logic [COEF_W-1:0]        coef_sel;
	logic signed [COEF_W:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_sh;
	logic signed [ST_W-1:0]   lp_cur;
	logic signed [ST_W-1:0]   sm_cur;
	logic signed [ST_W-1:0]   ho_cur;
	logic signed [LI_W-1:0]   li_cur;
	logic signed [ST_W-1:0]   lp_new;
	logic signed [ST_W-1:0]   sm_new;
	logic signed [R_W-1:0]    p;
	logic signed [LI_W-1:0]   q_new;
	logic signed [DQ_W-1:0]   dq;
	logic signed [OPND_W-1:0] hp_opnd;
	logic signed [YW_W-1:0]   y_w;
	logic signed [ST_W-1:0]   y_sat;
	logic signed [R_W-1:0]    r_new;
	logic signed [T_W-1:0]    t;
	logic signed [TR_W-1:0]   tr;
	logic signed [SMP_W-1:0]  out_sat;

	always_comb begin
		lp_cur = lp_q[ctl.ch];
		sm_cur = sm_q[ctl.ch];
		ho_cur = ho_q[ctl.ch];
		li_cur = li_q[ctl.ch];

		mix_sel = ctl.ch ? right_mix : left_mix;
		if (mix_sel > MIX_W'(spfc_pkg::SMP_MAX)) begin
			x = SMP_W'(spfc_pkg::SMP_MAX);
		end else if (mix_sel < MIX_W'(spfc_pkg::SMP_MIN)) begin
			x = SMP_W'(spfc_pkg::SMP_MIN);
		end else begin
			x = SMP_W'(mix_sel);
		end

		case (ctl.csel)
			spfc_pkg::CS_LP:   coef_sel = coef.lowpass;
			spfc_pkg::CS_SM:   coef_sel = coef.smoother;
			spfc_pkg::CS_GAIN: coef_sel = coef.gain;
			spfc_pkg::CS_HP:   coef_sel = coef.highpass;
			default:           coef_sel = coef.lowpass;
		endcase

		mul_a = $signed({1'b0, coef_sel});
		if (ctl.op == spfc_pkg::OP_MUL_HI) begin
			mul_b = MB_W'($signed(opnd_q[OPND_W-1:LO_W]));
		end else begin
			mul_b = MB_W'($signed({1'b0, opnd_q[LO_W-1:0]}));
		end
		prod = mul_a * mul_b;

		acc_sh = acc_q >>> COEF_FRAC;
		lp_new = lp_cur + ST_W'(acc_sh);
		sm_new = sm_cur + ST_W'(acc_sh);

		p = R_W'(lp_cur >>> FRAC_BITS);
		if (lp_cur[ST_W-1] && (|lp_cur[FRAC_BITS-1:0])) begin
			p = p + R_W'(1);
		end

		q_new = LI_W'(acc_q >>> GAIN_SH);
		if (acc_q[ACC_W-1] && (|acc_q[GAIN_SH-1:0])) begin
			q_new = q_new + LI_W'(1);
		end

		dq = DQ_W'(q_new) - DQ_W'(li_cur);
		hp_opnd = OPND_W'(ho_cur) + (OPND_W'(dq) <<< FRAC_BITS);

		y_w = YW_W'(acc_sh);
		if ((&y_w[YW_W-1:ST_W-1]) || !(|y_w[YW_W-1:ST_W-1])) begin
			y_sat = ST_W'(y_w);
		end else if (y_w[YW_W-1]) begin
			y_sat = $signed({1'b1, {(ST_W-1){1'b0}}});
		end else begin
			y_sat = $signed({1'b0, {(ST_W-1){1'b1}}});
		end

		r_new = R_W'(y_sat >>> FRAC_BITS);
		if (y_sat[ST_W-1] && (|y_sat[FRAC_BITS-1:0])) begin
			r_new = r_new + R_W'(1);
		end

		t = (T_W'(r_q) <<< OUT_FRAC) + T_W'(offset_add);
		tr = TR_W'(t >>> OUT_FRAC);
		if (t[T_W-1] && (|t[OUT_FRAC-1:0])) begin
			tr = tr + TR_W'(1);
		end
		if (tr > TR_W'(spfc_pkg::SMP_MAX)) begin
			out_sat = SMP_W'(spfc_pkg::SMP_MAX);
		end else if (tr < TR_W'(spfc_pkg::SMP_MIN)) begin
			out_sat = SMP_W'(spfc_pkg::SMP_MIN);
		end else begin
			out_sat = SMP_W'(tr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				lp_q[c] <= '0;
				sm_q[c] <= '0;
				ho_q[c] <= '0;
				li_q[c] <= '0;
			end
		end else begin
			case (ctl.op)
				spfc_pkg::OP_LP_UPD: lp_q[ctl.ch] <= lp_new;
				spfc_pkg::OP_SM_UPD: sm_q[ctl.ch] <= sm_new;
				spfc_pkg::OP_HP_UPD: begin
					ho_q[ctl.ch] <= y_sat;
					li_q[ctl.ch] <= q_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			spfc_pkg::OP_LP_DIFF: opnd_q <= (OPND_W'(x) <<< FRAC_BITS) - OPND_W'(lp_cur);
			spfc_pkg::OP_MUL_LO:  acc_q <= ACC_W'(prod);
			spfc_pkg::OP_MUL_HI:  acc_q <= acc_q + (ACC_W'(prod) <<< LO_W);
			spfc_pkg::OP_SM_DIFF: opnd_q <= (OPND_W'(p) <<< FRAC_BITS) - OPND_W'(sm_cur);
			spfc_pkg::OP_SM_UPD:  opnd_q <= OPND_W'(sm_new);
			spfc_pkg::OP_HP_DIFF: begin
				q_q    <= q_new;
				opnd_q <= hp_opnd;
			end
			spfc_pkg::OP_HP_UPD:  r_q <= r_new;
			spfc_pkg::OP_OUT:     res_q[ctl.ch] <= out_sat;
			default: ;
		endcase
	end

	assign left_res  = res_q[0];
	assign right_res = res_q[1];

endmodule

`default_nettype wire

/* src/stereo_post_filter_chain_core.sv */
`default_nettype none

// The core takes a new stereo request only once the previous one is done; a
// 15-step program runs per channel through one shared 17x25 multiplier, each
// product taking two steps, and one final step hands the pair to the output
// register and raises m_tvalid.
// A stalled output holds that final step, and s_tready stays low meanwhile.
// Reset (arst_n low, asynchronous): filter states clear to zero, registers
// return to their defaults, and the single output valid drops.

module stereo_post_filter_chain_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// left_mix[17:0], right_mix[35:18], offset_add[52:36], zero pad above
	input  wire logic [spfc_pkg::IN_TW-1:0]          s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// left_out[15:0], right_out[31:16]
	output logic [spfc_pkg::OUT_TW-1:0]              m_tdata,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [spfc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [spfc_pkg::COEF_W-1:0]         cfg_data
);

	localparam int PC_W  = spfc_pkg::PC_W;
	localparam int MIX_W = spfc_pkg::MIX_W;
	localparam int OFF_W = spfc_pkg::OFF_W;
	localparam int SMP_W = spfc_pkg::SMP_W;

	logic                     busy_q;
	logic [PC_W-1:0]          pc_q;
	logic                     ch_q;
	logic                     m_tvalid_q;
	logic [spfc_pkg::OUT_TW-1:0] m_tdata_q;
	spfc_pkg::coef_t          coef_q;
	logic signed [MIX_W-1:0]  left_mix_q;
	logic signed [MIX_W-1:0]  right_mix_q;
	logic signed [OFF_W-1:0]  offset_q;

	spfc_pkg::ucode_t         uw;
	spfc_pkg::ctl_t           ctl;
	logic signed [SMP_W-1:0]  left_res;
	logic signed [SMP_W-1:0]  right_res;
	logic                     in_fire;
	logic                     out_free;

	assign uw  = spfc_pkg::ucode_rom(pc_q);
	assign ctl = '{op: (busy_q ? uw.op : spfc_pkg::OP_NOP), csel: uw.csel, ch: ch_q};

	assign s_tready  = !busy_q;
	assign in_fire   = s_tvalid && !busy_q;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			pc_q           <= '0;
			ch_q           <= 1'b0;
			m_tvalid_q     <= 1'b0;
			coef_q.lowpass  <= spfc_pkg::RST_LOWPASS_COEF;
			coef_q.smoother <= spfc_pkg::RST_SMOOTHER_COEF;
			coef_q.gain     <= spfc_pkg::RST_MAKEUP_GAIN;
			coef_q.highpass <= spfc_pkg::RST_HIGHPASS_COEF;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					spfc_pkg::REG_LOWPASS_COEF:  coef_q.lowpass  <= cfg_data;
					spfc_pkg::REG_SMOOTHER_COEF: coef_q.smoother <= cfg_data;
					spfc_pkg::REG_MAKEUP_GAIN:   coef_q.gain     <= cfg_data;
					spfc_pkg::REG_HIGHPASS_COEF: coef_q.highpass <= cfg_data;
					default: ;
				endcase
			end

			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (!busy_q) begin
				if (in_fire) begin
					busy_q <= 1'b1;
					pc_q   <= '0;
					ch_q   <= 1'b0;
				end
			end else begin
				case (uw.op)
					spfc_pkg::OP_DONE: begin
						if (out_free) begin
							m_tvalid_q <= 1'b1;
							busy_q     <= 1'b0;
						end
					end
					default: begin
						if (uw.jmp && !ch_q) begin
							pc_q <= '0;
							ch_q <= 1'b1;
						end else begin
							pc_q <= pc_q + PC_W'(1);
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			left_mix_q  <= $signed(s_tdata[MIX_W-1:0]);
			right_mix_q <= $signed(s_tdata[2*MIX_W-1:MIX_W]);
			offset_q    <= $signed(s_tdata[2*MIX_W+OFF_W-1:2*MIX_W]);
		end
		if (busy_q && (uw.op == spfc_pkg::OP_DONE) && out_free) begin
			m_tdata_q <= {right_res, left_res};
		end
	end

	spfc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.coef       (coef_q),
		.left_mix   (left_mix_q),
		.right_mix  (right_mix_q),
		.offset_add (offset_q),
		.left_res   (left_res),
		.right_res  (right_res)
	);

`ifndef SYNTHESIS
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (busy_q && (pc_q == '0) && !ch_q))
		else $error("request taken but program did not start at step zero");

	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ch_q) |-> (busy_q && (pc_q == '0)))
		else $error("channel switched away from the program start");

	a_vrise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $fell(busy_q))
		else $error("result presented without finishing the program");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (uw.op == spfc_pkg::OP_DONE) && m_tvalid && !m_tready) |=> busy_q)
		else $error("result dropped while output still full");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;

	localparam int MIX_W     = spfc_pkg::MIX_W;
	localparam int OFF_W     = spfc_pkg::OFF_W;
	localparam int SMP_W     = spfc_pkg::SMP_W;
	localparam int COEF_W    = spfc_pkg::COEF_W;
	localparam int CFG_IDX_W = spfc_pkg::CFG_IDX_W;
	localparam int IN_TW     = spfc_pkg::IN_TW;
	localparam int OUT_TW    = spfc_pkg::OUT_TW;
	localparam int ST_W      = spfc_pkg::ST_W;
	localparam int FRAC_BITS = spfc_pkg::FRAC_BITS;
	localparam int COEF_FRAC = spfc_pkg::COEF_FRAC;
	localparam int GAIN_FRAC = spfc_pkg::GAIN_FRAC;
	localparam int OUT_FRAC  = spfc_pkg::OUT_FRAC;
	localparam int SMP_MAX   = spfc_pkg::SMP_MAX;
	localparam int SMP_MIN   = spfc_pkg::SMP_MIN;
	localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_COEF  = spfc_pkg::REG_LOWPASS_COEF;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHER_COEF = spfc_pkg::REG_SMOOTHER_COEF;
	localparam logic [CFG_IDX_W-1:0] REG_MAKEUP_GAIN   = spfc_pkg::REG_MAKEUP_GAIN;
	localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_COEF = spfc_pkg::REG_HIGHPASS_COEF;
	localparam logic [COEF_W-1:0] RST_LOWPASS_COEF  = spfc_pkg::RST_LOWPASS_COEF;
	localparam logic [COEF_W-1:0] RST_SMOOTHER_COEF = spfc_pkg::RST_SMOOTHER_COEF;
	localparam logic [COEF_W-1:0] RST_MAKEUP_GAIN   = spfc_pkg::RST_MAKEUP_GAIN;
	localparam logic [COEF_W-1:0] RST_HIGHPASS_COEF = spfc_pkg::RST_HIGHPASS_COEF;

	localparam int CYCLE_LIMIT = 600000;
	localparam int TAIL_CYCLES = 64;
	localparam int HOLD_CYCLES = 300;
	localparam int MIX_MAX = 2 ** (MIX_W - 1) - 1;
	localparam int MIX_MIN = -(2 ** (MIX_W - 1));
	localparam int OFF_MAX = 2 ** (OFF_W - 1) - 1;
	localparam int OFF_MIN = -(2 ** (OFF_W - 1));
	localparam int OFF_SPAN = 33792;
	localparam int LEVEL_SPAN = 40000;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED = '1;
	localparam logic [COEF_W-1:0] COEF_MAX = '1;
	localparam logic [12:0] STALL_PATTERN = 13'b1011001110100;

	typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;
	typedef enum {MIX_RAW, MIX_NOISE, MIX_HELD} mix_style_t;

	typedef struct {
		logic signed [MIX_W-1:0] left_mix;
		logic signed [MIX_W-1:0] right_mix;
		logic signed [OFF_W-1:0] offset_add;
	} frame_t;

	typedef struct {
		logic signed [SMP_W-1:0] left_out;
		logic signed [SMP_W-1:0] right_out;
	} stereo_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TW-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0] cfg_data = '0;

	logic [COEF_W-1:0] lp_coef, sm_coef, gain_coef, hp_coef;
	longint lp_state[2], sm_state[2], hp_prev_in[2], hp_prev_out[2];

	stereo_out_t pending_outputs[$];
	stereo_out_t head_out;
	int errors = 0;
	int frames_sent = 0;
	int outputs_checked = 0;
	int reg_writes = 0;
	int cycles = 0;

	sink_mode_t sink_mode = SINK_OPEN;
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;
	int hold_len = 0;
	int hold_left = 0;

	stereo_post_filter_chain_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("stereo_post_filter_chain_core verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= hold_len;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			case (sink_mode)
				SINK_OPEN: m_tready <= 1'b1;
				SINK_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= STALL_PATTERN[cycles % 13];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outputs.size() == 0) begin
				errors++;
				$display("%0t: output with none expected: left %0d right %0d", $time,
					$signed(m_tdata[SMP_W-1:0]), $signed(m_tdata[OUT_TW-1:SMP_W]));
			end else begin
				head_out = pending_outputs.pop_front();
				outputs_checked++;
				if (head_out.left_out !== m_tdata[SMP_W-1:0]) begin
					errors++;
					$display("%0t: left_out expected %0d, got %0d", $time,
						head_out.left_out, $signed(m_tdata[SMP_W-1:0]));
				end
				if (head_out.right_out !== m_tdata[OUT_TW-1:SMP_W]) begin
					errors++;
					$display("%0t: right_out expected %0d, got %0d", $time,
						head_out.right_out, $signed(m_tdata[OUT_TW-1:SMP_W]));
				end
			end
		end
	end

	function automatic longint trunc_shift(longint v, int s);
		return (v < 0) ? -((-v) >>> s) : (v >>> s);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic signed [SMP_W-1:0] filter_channel(int ch, longint mix,
			longint off);
		longint x, p, q, y, r, st_max;
		st_max = (longint'(1) <<< (ST_W - 1)) - 1;
		x = clip(mix, SMP_MIN, SMP_MAX);
		lp_state[ch] += (longint'(lp_coef) * ((x <<< FRAC_BITS) - lp_state[ch]))
			>>> COEF_FRAC;
		p = trunc_shift(lp_state[ch], FRAC_BITS);
		sm_state[ch] += (longint'(sm_coef) * ((p <<< FRAC_BITS) - sm_state[ch]))
			>>> COEF_FRAC;
		q = trunc_shift(sm_state[ch] * longint'(gain_coef), GAIN_FRAC + FRAC_BITS);
		y = (longint'(hp_coef) * (hp_prev_out[ch] + ((q - hp_prev_in[ch]) <<< FRAC_BITS)))
			>>> COEF_FRAC;
		y = clip(y, -st_max - 1, st_max);
		hp_prev_in[ch] = q;
		hp_prev_out[ch] = y;
		r = trunc_shift(y, FRAC_BITS);
		r = trunc_shift((r <<< OUT_FRAC) + off, OUT_FRAC);
		return SMP_W'(clip(r, SMP_MIN, SMP_MAX));
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return COEF_MAX;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic frame_t random_frame(mix_style_t style, int level_l, int level_r);
		frame_t f;
		case (style)
			MIX_RAW: begin
				f.left_mix = MIX_W'($urandom);
				f.right_mix = MIX_W'($urandom);
			end
			MIX_NOISE: begin
				f.left_mix = MIX_W'(int'($urandom_range(0, 65535)) - 32768);
				f.right_mix = MIX_W'(int'($urandom_range(0, 65535)) - 32768);
			end
			default: begin
				f.left_mix = MIX_W'(level_l + int'($urandom_range(0, 64)) - 32);
				f.right_mix = MIX_W'(level_r + int'($urandom_range(0, 64)) - 32);
			end
		endcase
		if ($urandom_range(0, 5) == 0)
			f.offset_add = OFF_W'($urandom);
		else
			f.offset_add = OFF_W'(int'($urandom_range(0, 2 * OFF_SPAN)) - OFF_SPAN);
		return f;
	endfunction

	task automatic send_frame(frame_t f);
		stereo_out_t want;
		s_tvalid <= 1'b1;
		s_tdata <= IN_TW'({f.offset_add, f.right_mix, f.left_mix});
		do @(posedge clk); while (!s_tready);
		want.left_out = filter_channel(0, f.left_mix, f.offset_add);
		want.right_out = filter_channel(1, f.right_mix, f.offset_add);
		pending_outputs.push_back(want);
		frames_sent++;
	endtask

	task automatic send_mix(int l, int r, int o);
		frame_t f;
		f.left_mix = MIX_W'(l);
		f.right_mix = MIX_W'(r);
		f.offset_add = OFF_W'(o);
		send_frame(f);
	endtask

	task automatic pause_sender(int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LOWPASS_COEF: lp_coef = val;
			REG_SMOOTHER_COEF: sm_coef = val;
			REG_MAKEUP_GAIN: gain_coef = val;
			REG_HIGHPASS_COEF: hp_coef = val;
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic load_coefs(logic [COEF_W-1:0] lp, logic [COEF_W-1:0] sm,
			logic [COEF_W-1:0] g, logic [COEF_W-1:0] hp);
		drain();
		write_reg(REG_LOWPASS_COEF, lp);
		write_reg(REG_SMOOTHER_COEF, sm);
		write_reg(REG_MAKEUP_GAIN, g);
		write_reg(REG_HIGHPASS_COEF, hp);
	endtask

	task automatic test_defaults();
		sink_mode = SINK_OPEN;
		send_mix(0, 0, 0);
		send_mix(SMP_MAX, SMP_MIN, 0);
		send_mix(SMP_MAX + 1, SMP_MIN - 1, OFF_SPAN);
		send_mix(MIX_MAX, MIX_MIN, -OFF_SPAN);
		send_mix(MIX_MIN, MIX_MAX, OFF_MAX);
		send_mix(MIX_MAX, MIX_MAX, OFF_MIN);
		send_mix(MIX_MIN, MIX_MIN, OFF_MAX);
		send_mix(-1, 1, -1);
		send_mix(SMP_MAX, SMP_MAX, 1);
		send_mix(SMP_MIN, SMP_MIN, OFF_MIN);
		send_mix(12345, -12345, 0);
		drain();
	endtask

	task automatic test_extreme_settings();
		load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		sink_mode = SINK_RANDOM;
		// drive the sum past full scale in both directions
		repeat (3) send_mix(SMP_MAX, SMP_MAX, OFF_MAX);
		repeat (3) send_mix(MIX_MIN, SMP_MIN, OFF_MIN);
		send_mix(MIX_MAX, MIX_MIN, 0);
		drain();
		write_reg(REG_FIRST_UNUSED, '0);
		write_reg(REG_LAST_UNUSED, '0);
		send_mix(SMP_MAX, SMP_MIN, OFF_SPAN);
		send_mix(0, 0, -OFF_SPAN);
		load_coefs('0, '0, '0, '0);
		send_mix(SMP_MAX, SMP_MIN, OFF_MAX);
		send_mix(MIX_MIN, MIX_MAX, OFF_MIN);
		drain();
	endtask

	task automatic test_backpressure();
		sink_mode = SINK_OPEN;
		// hold the output side off so the core backs up into its input
		hold_len = HOLD_CYCLES;
		hold_req <= ~hold_req;
		repeat (10) send_frame(random_frame(MIX_NOISE, 0, 0));
		drain();
	endtask

	task automatic run_random_traffic(int count);
		int sent;
		int burst;
		int pick;
		int level_l;
		int level_r;
		mix_style_t style;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			pick = $urandom_range(0, 5);
			style = (pick == 0) ? MIX_RAW : ((pick < 3) ? MIX_NOISE : MIX_HELD);
			level_l = int'($urandom_range(0, 2 * LEVEL_SPAN)) - LEVEL_SPAN;
			level_r = int'($urandom_range(0, 2 * LEVEL_SPAN)) - LEVEL_SPAN;
			repeat (burst) begin
				send_frame(random_frame(style, level_l, level_r));
				sent++;
			end
			pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
		end
		drain();
	endtask

	task automatic test_random_settings();
		load_coefs(RST_LOWPASS_COEF, RST_SMOOTHER_COEF, RST_MAKEUP_GAIN, RST_HIGHPASS_COEF);
		sink_mode = SINK_PATTERN;
		run_random_traffic(160);
		for (int phase = 0; phase < 5; phase++) begin
			load_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
			sink_mode = sink_mode_t'(phase % 3);
			run_random_traffic(160);
		end
	endtask

	initial begin
		lp_coef = RST_LOWPASS_COEF;
		sm_coef = RST_SMOOTHER_COEF;
		gain_coef = RST_MAKEUP_GAIN;
		hp_coef = RST_HIGHPASS_COEF;
		for (int c = 0; c < 2; c++) begin
			lp_state[c] = 0;
			sm_state[c] = 0;
			hp_prev_in[c] = 0;
			hp_prev_out[c] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_extreme_settings();
		test_backpressure();
		test_random_settings();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d stereo requests, %0d outputs checked, %0d register writes,",
			frames_sent, outputs_checked, reg_writes);
		$display("over reset, zero, full-scale and random coefficient sets with stalls.");
		if (errors == 0)
			$display("stereo_post_filter_chain_core verification clean");
		else
			$display("stereo_post_filter_chain_core verification failed");
		$finish;
	end

endmodule
